[sv/thc_pkg.sv]
// ----------------------------------------------------------------------------
// thc_pkg
// Shared types and constants of the hysteresis thermostat controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package thc_pkg;

  localparam int unsigned TEMP_W  = 16;
  localparam int unsigned BAND_W  = 8;
  localparam int unsigned TIME_W  = 22;
  // Ages saturate above any programmable limit, so one extra bit suffices.
  localparam int unsigned AGE_W   = TIME_W + 1;
  // Band edges at full width: 16-bit setpoint plus or minus 8-bit band.
  localparam int unsigned EDGE_W  = TEMP_W + 2;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned DRIVE_W = 2;
  localparam int unsigned CFG_IDX_W = 4;

  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EVAL   = 2'd2;

  localparam logic [DRIVE_W-1:0] DRIVE_IDLE = 2'd0;
  localparam logic [DRIVE_W-1:0] DRIVE_HEAT = 2'd1;
  localparam logic [DRIVE_W-1:0] DRIVE_COOL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STALE    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DWELL    = 4'd3;

  localparam logic signed [TEMP_W-1:0] SETPOINT_RST = 16'sd200;
  localparam logic [BAND_W-1:0]        BAND_RST     = 8'd10;
  localparam logic [TIME_W-1:0]        STALE_RST    = 22'd5000;
  localparam logic [TIME_W-1:0]        DWELL_RST    = 22'd60000;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_HEAT = 3'b010,
    ST_COOL = 3'b100
  } state_e;

endpackage

`default_nettype wire

[sv/thermostat_hysteresis_controller.sv]
// ----------------------------------------------------------------------------
// thermostat_hysteresis_controller
// An evaluation passes through the input register, then the result register.
// Throughput: one item per cycle while no evaluation meets a stalled result,
// set by the single input-register to result-register pass; a stalled result
// holds one further item in the input register. Reset clears stored sample,
// ages, mode and valids and loads the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module thermostat_hysteresis_controller (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire [thc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire [thc_pkg::TIME_W-1:0]         cfg_data_i,
  input  wire                               in_valid_i,
  output logic                              in_stall_o,
  input  wire [thc_pkg::KIND_W-1:0]         mode_i,
  input  wire signed [thc_pkg::TEMP_W-1:0]  sample_deci_c_i,
  input  wire                               heat_relay_feedback_i,
  input  wire                               cool_relay_feedback_i,
  output logic                              out_valid_o,
  input  wire                               out_stall_i,
  output logic [thc_pkg::DRIVE_W-1:0]       drive_mode_o,
  output logic signed [thc_pkg::TEMP_W-1:0] reported_deci_c_o,
  output logic                              heat_fb_echo_o,
  output logic                              cool_fb_echo_o,
  output logic                              fault_stale_o,
  output logic                              fault_heat_mismatch_o,
  output logic                              fault_cool_mismatch_o,
  output logic                              reading_valid_o
);
  import thc_pkg::*;

  logic signed [TEMP_W-1:0] setpoint_q;
  logic [BAND_W-1:0]        band_q;
  logic [TIME_W-1:0]        stale_q;
  logic [TIME_W-1:0]        dwell_min_q;

  logic                     in_valid_q;
  logic [KIND_W-1:0]        kind_q;
  logic signed [TEMP_W-1:0] in_temp_q;
  logic                     in_heat_q;
  logic                     in_cool_q;

  logic signed [TEMP_W-1:0] last_q, last_d;
  logic                     seen_q, seen_d;
  logic [AGE_W-1:0]         age_q, age_d;
  logic [AGE_W-1:0]         dwell_q, dwell_d;
  state_e                   state_q, state_d;

  logic                     out_valid_q, out_valid_d;
  logic [DRIVE_W-1:0]       drive_q;
  logic signed [TEMP_W-1:0] rep_q;
  logic                     heat_echo_q, cool_echo_q;
  logic                     stale_flt_q, heat_mis_q, cool_mis_q, rd_valid_q;

  logic                     is_eval;
  logic                     proc_fire;
  logic                     in_fire;
  logic                     aged;
  logic                     stale;
  logic                     dwell_hold;
  logic signed [EDGE_W-1:0] temp_x, sp_x, lo_x, hi_x;
  state_e                   want;
  logic [DRIVE_W-1:0]       drive_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q  <= SETPOINT_RST;
      band_q      <= BAND_RST;
      stale_q     <= STALE_RST;
      dwell_min_q <= DWELL_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SETPOINT: setpoint_q  <= cfg_data_i[TEMP_W-1:0];
        REG_BAND:     band_q      <= cfg_data_i[BAND_W-1:0];
        REG_STALE:    stale_q     <= cfg_data_i;
        REG_DWELL:    dwell_min_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign is_eval    = (kind_q == KIND_EVAL);
  assign proc_fire  = in_valid_q && !(is_eval && out_valid_q && out_stall_i);
  assign in_stall_o = in_valid_q && !proc_fire;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (proc_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q    <= mode_i;
      in_temp_q <= sample_deci_c_i;
      in_heat_q <= heat_relay_feedback_i;
      in_cool_q <= cool_relay_feedback_i;
    end
  end

  assign aged   = seen_q && (age_q > {1'b0, stale_q});
  assign stale  = !seen_q || aged;
  assign temp_x = EDGE_W'(last_q);
  assign sp_x   = EDGE_W'(setpoint_q);
  assign lo_x   = sp_x - $signed({{(EDGE_W-BAND_W){1'b0}}, band_q});
  assign hi_x   = sp_x + $signed({{(EDGE_W-BAND_W){1'b0}}, band_q});
  assign dwell_hold = (dwell_q < {1'b0, dwell_min_q});

  always_comb begin
    want = state_q;
    if (stale) begin
      want = ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (temp_x < lo_x) begin
            want = ST_HEAT;
          end else if (temp_x > hi_x) begin
            want = ST_COOL;
          end
        end
        ST_HEAT: begin
          if (temp_x >= sp_x && !dwell_hold) want = ST_IDLE;
        end
        ST_COOL: begin
          if (temp_x <= sp_x && !dwell_hold) want = ST_IDLE;
        end
        default: want = ST_IDLE;
      endcase
    end
  end

  always_comb begin
    last_d  = last_q;
    seen_d  = seen_q;
    age_d   = age_q;
    dwell_d = dwell_q;
    state_d = state_q;
    if (proc_fire) begin
      case (kind_q)
        KIND_TICK: begin
          age_d   = (age_q == '1) ? age_q : age_q + 1'b1;
          dwell_d = (dwell_q == '1) ? dwell_q : dwell_q + 1'b1;
        end
        KIND_SAMPLE: begin
          last_d = in_temp_q;
          seen_d = 1'b1;
          age_d  = '0;
        end
        KIND_EVAL: begin
          state_d = want;
          if (want != state_q) dwell_d = '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (want)
      ST_HEAT: drive_d = DRIVE_HEAT;
      ST_COOL: drive_d = DRIVE_COOL;
      default: drive_d = DRIVE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      seen_q  <= 1'b0;
      age_q   <= '0;
      dwell_q <= '0;
      state_q <= ST_IDLE;
    end else begin
      last_q  <= last_d;
      seen_q  <= seen_d;
      age_q   <= age_d;
      dwell_q <= dwell_d;
      state_q <= state_d;
    end
  end

  assign out_valid_d = (proc_fire && is_eval) || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire && is_eval) begin
      drive_q     <= drive_d;
      rep_q       <= last_q;
      heat_echo_q <= in_heat_q;
      cool_echo_q <= in_cool_q;
      stale_flt_q <= aged;
      heat_mis_q  <= (want == ST_HEAT) != in_heat_q;
      cool_mis_q  <= (want == ST_COOL) != in_cool_q;
      rd_valid_q  <= !stale;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign drive_mode_o          = drive_q;
  assign reported_deci_c_o     = rep_q;
  assign heat_fb_echo_o        = heat_echo_q;
  assign cool_fb_echo_o        = cool_echo_q;
  assign fault_stale_o         = stale_flt_q;
  assign fault_heat_mismatch_o = heat_mis_q;
  assign fault_cool_mismatch_o = cool_mis_q;
  assign reading_valid_o       = rd_valid_q;

  // An active drive needs a fresh reading.
  a_active_needs_reading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (drive_mode_o != DRIVE_IDLE) |-> reading_valid_o)
    else $error("active drive without valid reading");

  a_stale_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(fault_stale_o && reading_valid_o))
    else $error("stale fault with valid reading");

  a_sample_clears_age: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_fire && (kind_q == KIND_SAMPLE) |=> (age_q == '0) && seen_q)
    else $error("sample did not restart age");

endmodule

`default_nettype wire
